[sv/isme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isme_pkg
// Shared types and constants of the interval set merge engine: command and
// status codes, default sizes and the control bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package isme_pkg;

    localparam int MAX_SPANS_DEF = 16;
    localparam int POS_BITS_DEF  = 16;

    localparam int CMD_W     = 2;
    localparam int STAT_W    = 2;
    localparam int IN_POS_W  = 16;
    localparam int CNT_OUT_W = 5;
    localparam int IN_DATA_W = 2 * IN_POS_W;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_BAD  = 2'd1,
        STAT_FULL = 2'd2
    } stat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic scan_init;
        logic scan_en;
        logic eval_merge;
        logic eval_build;
        logic eval_query;
        logic commit;
        logic clear;
        logic set_bad;
        logic set_full;
        logic out_load;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             bad_range;
        logic             would_full;
        logic             scan_done;
        logic             out_free;
    } ctrl_stat_t;

endpackage

[sv/interval_set_merge_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_merge_engine_core
// Sorted set of disjoint half-open intervals with add, query and clear.
// ----------------------------------------------------------------------------
// One command is worked at a time. An add and a query scan the table
// memory, one entry per cycle through its single read port: an add makes
// one pass to find the merged span and count the entries before and after
// it, and a second pass that copies the kept entries into the other half of
// the memory, which then becomes the live table; a query makes one pass. A
// full table is detected after the first pass and leaves the set untouched.
// A clear, an unused command or a rejected empty or inverted add scans
// nothing. The result waits in an output register, so the next command is
// accepted while it is still held; the result of that next command waits
// until the held one is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module interval_set_merge_engine_core #(
    parameter int MAX_SPANS = isme_pkg::MAX_SPANS_DEF,
    parameter int POS_BITS  = isme_pkg::POS_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: first_pos[15:0], end_pos[31:16]
    input  logic [isme_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [isme_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: live_hit[0], status[2:1], interval_count[7:3]
    output logic [isme_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import isme_pkg::*;

    ctrl_cmd_t             ctl_cmd;
    ctrl_stat_t            ctl_stat;
    logic                  out_hit;
    logic [STAT_W-1:0]     out_status;
    logic [CNT_OUT_W-1:0]  out_count;

    isme_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (ctl_stat),
        .cmd      (ctl_cmd)
    );

    isme_datapath #(
        .MAX_SPANS (MAX_SPANS),
        .POS_BITS  (POS_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (ctl_cmd),
        .stat       (ctl_stat),
        .in_cmd     (s_axis_tuser),
        .in_first   (s_axis_tdata[IN_POS_W-1:0]),
        .in_end     (s_axis_tdata[IN_DATA_W-1:IN_POS_W]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_hit    (out_hit),
        .out_status (out_status),
        .out_count  (out_count)
    );

    assign m_axis_tdata = {out_count, out_status, out_hit};

endmodule

[sv/isme_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isme_datapath
// Interval table in a ping-pong memory, the scan pipeline, the merge
// accumulators and the result register.
// ----------------------------------------------------------------------------
module isme_datapath #(
    parameter int MAX_SPANS = isme_pkg::MAX_SPANS_DEF,
    parameter int POS_BITS  = isme_pkg::POS_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  isme_pkg::ctrl_cmd_t           cmd,
    output isme_pkg::ctrl_stat_t          stat,
    input  logic [isme_pkg::CMD_W-1:0]    in_cmd,
    input  logic [isme_pkg::IN_POS_W-1:0] in_first,
    input  logic [isme_pkg::IN_POS_W-1:0] in_end,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_hit,
    output logic [isme_pkg::STAT_W-1:0]   out_status,
    output logic [isme_pkg::CNT_OUT_W-1:0] out_count
);
    import isme_pkg::*;

    localparam int IDX_W = $clog2(MAX_SPANS);
    localparam int CNT_W = $clog2(MAX_SPANS + 1);
    localparam int DEPTH = 2 ** (IDX_W + 1);
    localparam int ENT_W = 2 * POS_BITS;

    // Each half of the memory holds one full table; an add copies the
    // surviving entries into the idle half and then swaps halves.
    logic [ENT_W-1:0] span_mem [0:DEPTH-1];

    logic                bank_reg, bank_next;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [ENT_W-1:0]    rd_data_reg;
    logic [CMD_W-1:0]    op_reg;
    logic [POS_BITS-1:0] s_reg, e_reg;
    logic [POS_BITS-1:0] mb_reg, mb_next;
    logic [POS_BITS-1:0] mf_reg, mf_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    wr_n_reg, wr_n_next;
    logic                hit_reg, hit_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic                out_vld_reg, out_vld_next;
    logic                out_hit_reg;
    logic [STAT_W-1:0]   out_stat_reg;
    logic [CNT_OUT_W-1:0] out_cnt_reg;

    logic [POS_BITS+IN_POS_W-1:0] first_ext, end_ext;
    logic [POS_BITS-1:0] rd_b, rd_f;
    logic                rd_issue;
    logic                is_lo, is_hi, is_ovl;
    logic [CNT_W:0]      new_total;
    logic [CNT_W-1:0]    wr_pos;
    logic                wr_en;
    logic [IDX_W:0]      wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

    assign first_ext = {{POS_BITS{1'b0}}, in_first};
    assign end_ext   = {{POS_BITS{1'b0}}, in_end};

    assign rd_b = rd_data_reg[ENT_W-1:POS_BITS];
    assign rd_f = rd_data_reg[POS_BITS-1:0];

    assign rd_issue = cmd.scan_en && (rd_idx_reg < total_reg);

    // Against a sorted, disjoint, non-touching table these three classes
    // match the before, after and absorbed cases of the merged span.
    assign is_lo  = rd_f < s_reg;
    assign is_hi  = rd_b > e_reg;
    assign is_ovl = !is_lo && !is_hi;

    assign new_total = {1'b0, lo_reg} + {1'b0, hi_reg} + (CNT_W+1)'(1);

    assign wr_pos = is_hi ? (wr_n_reg + CNT_W'(1)) : wr_n_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {!bank_reg, wr_pos[IDX_W-1:0]};
        wr_data = rd_data_reg;
        if (cmd.commit)
        begin
            wr_en   = 1'b1;
            wr_addr = {!bank_reg, lo_reg[IDX_W-1:0]};
            wr_data = {mb_reg, mf_reg};
        end
        else if (cmd.eval_build && rd_vld_reg && !is_ovl)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            span_mem[wr_addr] <= wr_data;
        end
        if (rd_issue)
        begin
            rd_data_reg <= span_mem[{bank_reg, rd_idx_reg[IDX_W-1:0]}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg <= in_cmd;
            s_reg  <= first_ext[POS_BITS-1:0];
            e_reg  <= end_ext[POS_BITS-1:0];
        end
    end

    always_comb
    begin
        bank_next   = bank_reg;
        total_next  = total_reg;
        rd_idx_next = rd_idx_reg;
        rd_vld_next = 1'b0;
        mb_next     = mb_reg;
        mf_next     = mf_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        wr_n_next   = wr_n_reg;
        hit_next    = hit_reg;
        stat_next   = stat_reg;

        if (cmd.latch)
        begin
            hit_next  = 1'b0;
            stat_next = STAT_OK;
            lo_next   = '0;
            hi_next   = '0;
            wr_n_next = '0;
        end

        if (cmd.scan_init)
        begin
            rd_idx_next = '0;
            rd_vld_next = 1'b0;
            if (!cmd.eval_build)
            begin
                mb_next = s_reg;
                mf_next = e_reg;
            end
        end
        else if (rd_issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            rd_vld_next = 1'b1;
        end

        if (rd_vld_reg)
        begin
            if (cmd.eval_merge)
            begin
                if (is_lo)
                begin
                    lo_next = lo_reg + CNT_W'(1);
                end
                if (is_hi)
                begin
                    hi_next = hi_reg + CNT_W'(1);
                end
                if (is_ovl)
                begin
                    if (rd_b < mb_reg)
                    begin
                        mb_next = rd_b;
                    end
                    if (rd_f > mf_reg)
                    begin
                        mf_next = rd_f;
                    end
                end
            end
            if (cmd.eval_build && !is_ovl)
            begin
                wr_n_next = wr_n_reg + CNT_W'(1);
            end
            if (cmd.eval_query && (rd_b <= s_reg) && (s_reg < rd_f))
            begin
                hit_next = 1'b1;
            end
        end

        if (cmd.commit)
        begin
            bank_next  = !bank_reg;
            total_next = new_total[CNT_W-1:0];
        end
        if (cmd.clear)
        begin
            total_next = '0;
        end
        if (cmd.set_bad)
        begin
            stat_next = STAT_BAD;
        end
        if (cmd.set_full)
        begin
            stat_next = STAT_FULL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg   <= 1'b0;
            total_reg  <= '0;
            rd_idx_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            bank_reg   <= bank_next;
            total_reg  <= total_next;
            rd_idx_reg <= rd_idx_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mb_reg   <= mb_next;
        mf_reg   <= mf_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        wr_n_reg <= wr_n_next;
        hit_reg  <= hit_next;
        stat_reg <= stat_next;
    end

    // Result register; a new command may start while it waits.
    assign cnt_ext = {{CNT_OUT_W{1'b0}}, total_reg};

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_hit_reg  <= hit_reg;
            out_stat_reg <= stat_reg;
            out_cnt_reg  <= cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_hit    = out_hit_reg;
    assign out_status = out_stat_reg;
    assign out_count  = out_cnt_reg;

    assign stat.op         = op_reg;
    assign stat.bad_range  = s_reg >= e_reg;
    assign stat.would_full = new_total > (CNT_W+1)'(MAX_SPANS);
    assign stat.scan_done  = (rd_idx_reg == total_reg) && !rd_vld_reg;
    assign stat.out_free   = !out_vld_reg || out_ready;

endmodule

[sv/isme_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isme_controller
// Command sequencer: dispatches each command and steps the datapath through
// the merge, build and query scans of the interval table.
// ----------------------------------------------------------------------------
module isme_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  isme_pkg::ctrl_stat_t stat,
    output isme_pkg::ctrl_cmd_t  cmd
);
    import isme_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_MERGE    = 7'b0000100,
        ST_BUILD    = 7'b0001000,
        ST_COMMIT   = 7'b0010000,
        ST_QUERY    = 7'b0100000,
        ST_REPLY    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                cmd.scan_init = 1'b1;
                unique case (stat.op)
                    CMD_ADD:
                    begin
                        if (stat.bad_range)
                        begin
                            cmd.set_bad = 1'b1;
                            state_next  = ST_REPLY;
                        end
                        else
                        begin
                            state_next = ST_MERGE;
                        end
                    end
                    CMD_QUERY:
                    begin
                        state_next = ST_QUERY;
                    end
                    CMD_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_REPLY;
                    end
                    default:
                    begin
                        state_next = ST_REPLY;
                    end
                endcase
            end
            ST_MERGE:
            begin
                cmd.scan_en    = 1'b1;
                cmd.eval_merge = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.would_full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = ST_REPLY;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        cmd.eval_build = 1'b1;
                        state_next    = ST_BUILD;
                    end
                end
            end
            ST_BUILD:
            begin
                cmd.scan_en    = 1'b1;
                cmd.eval_build = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_REPLY;
            end
            ST_QUERY:
            begin
                cmd.scan_en    = 1'b1;
                cmd.eval_query = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/isme_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isme_checker
// Port-level checks of the interval set merge engine, bound to the top level.
// ----------------------------------------------------------------------------
module isme_checker #(
    parameter int MAX_SPANS = isme_pkg::MAX_SPANS_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [isme_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import isme_pkg::*;

    // A held result must not vanish before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // Commands are worked one at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second command accepted while one is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] == STAT_OK) ||
                          (m_axis_tdata[2:1] == STAT_BAD) ||
                          (m_axis_tdata[2:1] == STAT_FULL))
        else $error("undefined status code");

    // Only a query can hit, and a query never fails.
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2:1] == STAT_OK)
        else $error("hit reported with an error status");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (MAX_SPANS >= 32) || (int'(m_axis_tdata[7:3]) <= MAX_SPANS))
        else $error("interval count above table depth");

endmodule

bind interval_set_merge_engine_core isme_checker #(
    .MAX_SPANS (MAX_SPANS)
) u_isme_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
